FILE: src/positional_ordered_list_unit_assert.svh
// assertion macros for the positional ordered list unit
// used by modules that check their own logic; expects i_clk and i_rst_n in scope
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define POL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define POL_ASSERT_IMP(lbl, ante, cons, msg)
`define POL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/pol_pkg.sv
// shared types and constants for the positional ordered list unit
// no dependencies
package pol_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = ((CNT_W > 9) ? CNT_W : 9) + 1;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 9;
    localparam int COUNT_W   = 5;
    localparam int FOUND_W   = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_SEARCH = 2'd3
    } t_mode;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] at;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

FILE: src/pol_cell.sv
// one storage cell of the list: holds one entry, shifts with its neighbors
// depends on pol_pkg
module pol_cell (
    input  logic                       i_clk,
    input  pol_pkg::t_cell_ctl         i_ctl,
    input  logic [pol_pkg::IDX_W-1:0]  i_index,
    input  logic [pol_pkg::VAL_W-1:0]  i_left,
    input  logic [pol_pkg::VAL_W-1:0]  i_right,
    output logic [pol_pkg::VAL_W-1:0]  o_entry,
    output logic                       o_match
);

    logic [pol_pkg::VAL_W-1:0] r_entry;
    logic [pol_pkg::VAL_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins && (i_index > i_ctl.at)) begin
            n_entry = i_left;
        end else if (i_ctl.ins && (i_index == i_ctl.at)) begin
            n_entry = i_ctl.value;
        end else if (i_ctl.rem && (i_index >= i_ctl.at)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_ctl.value);

endmodule

FILE: src/positional_ordered_list_unit.sv
// top level of the positional ordered list unit: request decode, fill count,
// cell row and result register; depends on pol_pkg, pol_cell and the assert header
//
// The unit keeps up to CAPACITY signed 32-bit entries in position order in a row
// of cells and serves one request per clock: insert, remove, read or search.
// Every cell shifts or compares in the same cycle, so a request is accepted every
// cycle while the result register is empty or being taken, and its result
// appears in the cycle after acceptance. The fill count register, updated with
// the cell row, sets this rate.
`include "positional_ordered_list_unit_assert.svh"

module positional_ordered_list_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // position [8:0], value [40:9]
    input  logic [pol_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // data [31:0], count [36:32], found_index [41:37]
    output logic [pol_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // status [0]
    output logic [0:0]                      o_m_axis_tuser
);

    logic                         w_acc;
    pol_pkg::t_mode               w_mode;
    logic [pol_pkg::POS_W-1:0]    w_pos;
    logic [pol_pkg::VAL_W-1:0]    w_val;
    logic                         w_m1;
    logic                         w_bad;
    logic                         w_full;
    logic                         w_empty;
    logic [pol_pkg::CMP_W-1:0]    w_pos_u;
    logic [pol_pkg::CMP_W-1:0]    w_fill_c;
    logic [pol_pkg::IDX_W-1:0]    w_pidx;
    logic [pol_pkg::IDX_W-1:0]    w_last;
    logic [pol_pkg::VAL_W-1:0]    w_entry [pol_pkg::CAPACITY];
    logic [pol_pkg::CAPACITY-1:0] w_match;
    logic                         w_hit;
    logic [pol_pkg::IDX_W-1:0]    w_hit_idx;
    pol_pkg::t_cell_ctl           w_ctl;
    logic [pol_pkg::IDX_W-1:0]    w_at;

    logic [pol_pkg::CNT_W-1:0]    r_fill;
    logic [pol_pkg::CNT_W-1:0]    n_fill;
    logic                         n_status;
    logic [pol_pkg::VAL_W-1:0]    n_data;
    logic [pol_pkg::FOUND_W-1:0]  n_found;

    logic                         r_out_valid;
    logic                         r_out_status;
    logic [pol_pkg::VAL_W-1:0]    r_out_data;
    logic [pol_pkg::COUNT_W-1:0]  r_out_count;
    logic [pol_pkg::FOUND_W-1:0]  r_out_found;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode   = pol_pkg::t_mode'(i_s_axis_tuser);
    assign w_pos    = i_s_axis_tdata[pol_pkg::POS_W-1:0];
    assign w_val    = i_s_axis_tdata[pol_pkg::POS_W +: pol_pkg::VAL_W];
    assign w_m1     = (w_pos == '1);
    assign w_bad    = w_pos[pol_pkg::POS_W-1] && !w_m1;
    assign w_full   = (r_fill >= pol_pkg::CNT_W'(pol_pkg::CAPACITY));
    assign w_empty  = (r_fill == '0);
    assign w_pos_u  = pol_pkg::CMP_W'(w_pos[pol_pkg::POS_W-2:0]);
    assign w_fill_c = pol_pkg::CMP_W'(r_fill);
    assign w_pidx   = pol_pkg::IDX_W'(w_pos[pol_pkg::POS_W-2:0]);
    assign w_last   = pol_pkg::IDX_W'(r_fill - pol_pkg::CNT_W'(1));

    // cell row
    for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_cell
        logic [pol_pkg::VAL_W-1:0] w_left;
        logic [pol_pkg::VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_entry[g];
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end
        if (g == pol_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (pol_pkg::IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // first match below the fill count
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = pol_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (w_match[i] && (pol_pkg::CNT_W'(i) < r_fill)) begin
                w_hit     = 1'b1;
                w_hit_idx = pol_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_fill    = r_fill;
        n_status  = 1'b0;
        n_data    = '0;
        n_found   = '1;
        w_at      = '0;
        w_ctl.ins = 1'b0;
        w_ctl.rem = 1'b0;
        w_ctl.value = w_val;
        unique case (w_mode)
            pol_pkg::MODE_INSERT: begin
                if (w_bad || w_full) begin
                    n_status = 1'b1;
                end else begin
                    w_ctl.ins = w_acc;
                    n_fill    = r_fill + pol_pkg::CNT_W'(1);
                    if ((w_pos == '0) || w_empty) begin
                        w_at = '0;
                    end else if (w_m1 || (w_pos_u >= w_fill_c)) begin
                        w_at = pol_pkg::IDX_W'(r_fill);
                    end else begin
                        w_at = w_pidx;
                    end
                end
            end
            pol_pkg::MODE_REMOVE: begin
                if (w_bad || w_empty) begin
                    n_status = 1'b1;
                end else begin
                    w_ctl.rem = w_acc;
                    n_fill    = r_fill - pol_pkg::CNT_W'(1);
                    if (w_pos == '0) begin
                        w_at = '0;
                    end else if (w_m1 || (w_pos_u >= (w_fill_c - pol_pkg::CMP_W'(1)))) begin
                        w_at = w_last;
                    end else begin
                        w_at = w_pidx;
                    end
                    n_data = w_entry[w_at];
                end
            end
            pol_pkg::MODE_READ: begin
                if (w_bad || w_empty || (!w_m1 && (w_pos_u >= w_fill_c))) begin
                    n_status = 1'b1;
                end else begin
                    w_at   = w_m1 ? w_last : w_pidx;
                    n_data = w_entry[w_at];
                end
            end
            pol_pkg::MODE_SEARCH: begin
                n_found = w_hit ? pol_pkg::FOUND_W'(w_hit_idx) : '1;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
        w_ctl.at = w_at;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_fill      <= n_fill;
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_status <= n_status;
            r_out_data   <= n_data;
            r_out_count  <= pol_pkg::COUNT_W'(n_fill);
            r_out_found  <= n_found;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {
        (pol_pkg::OUT_DATA_W - pol_pkg::VAL_W - pol_pkg::COUNT_W - pol_pkg::FOUND_W)'(0),
        r_out_found, r_out_count, r_out_data
    };

    `POL_ASSERT_IMP(a_fill_max, 1'b1, r_fill <= pol_pkg::CNT_W'(pol_pkg::CAPACITY), "fill above capacity")
    `POL_ASSERT_NEXT(a_insert_grows, w_acc && (w_mode == pol_pkg::MODE_INSERT) && !w_bad && !w_full, r_fill == pol_pkg::CNT_W'($past(r_fill) + pol_pkg::CNT_W'(1)), "insert did not grow fill")
    `POL_ASSERT_NEXT(a_search_keeps, w_acc && (w_mode == pol_pkg::MODE_SEARCH), r_fill == $past(r_fill), "search changed fill")
    `POL_ASSERT_IMP(a_err_zero, r_out_valid && r_out_status, (r_out_data == '0) && (r_out_found == '1), "error result carries data")

endmodule
